// ----- rtl/core/threshold_blend_rect_engine_defines.svh -----
// Assertion macros shared by the checker of the threshold blend rectangle engine.
`ifndef THRESHOLD_BLEND_RECT_ENGINE_DEFINES_SVH
`define THRESHOLD_BLEND_RECT_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define TBRE_ASSERT_IMPLY(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("threshold_blend_rect_engine: implication failed");

// Next-cycle implication, also checked across reset.
`define TBRE_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("threshold_blend_rect_engine: next-cycle check failed");

`endif

// ----- rtl/core/tbre_pkg.sv -----
// Types, codes and the blend function of the threshold blend rectangle engine.
package tbre_pkg;

  localparam logic [1:0] OP_BLEND = 2'd0;
  localparam logic [1:0] OP_FILL  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_REGION_WIDTH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_REGION_HEIGHT = 2'd3;

  localparam logic [31:0] BLEND_REPLACE = 32'hA000_0000;
  localparam logic [31:0] BLEND_AVERAGE = 32'h4000_0000;
  localparam logic [31:0] HALF_MASK     = 32'hFEFE_FEFE;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [31:0] pixel;
    logic [8:0]  rect_width;
    logic [8:0]  rect_height;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_pixel;
    logic        out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [8:0]  region_width;
    logic [8:0]  region_height;
  } cfg_t;

  typedef struct packed {
    logic        is_read;
    logic [12:0] x;
    logic [12:0] y;
    logic [31:0] pixel;
  } job_t;

  typedef enum logic {
    F_IDLE,
    F_FILL
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_ADDR,
    B_READ,
    B_DATA,
    B_RESULT
  } back_state_t;

  function automatic logic [31:0] blend(input logic [31:0] dst, input logic [31:0] src);
    logic [31:0] avg;
    avg = ((dst & HALF_MASK) >> 1) + ((src & HALF_MASK) >> 1);
    if (src >= BLEND_REPLACE) begin
      return src;
    end else if (src >= BLEND_AVERAGE) begin
      return avg;
    end else begin
      return dst;
    end
  endfunction

endpackage

// ----- rtl/core/threshold_blend_rect_engine.sv -----
// Threshold blend rectangle engine: an ARGB frame store for one screen region with
// blended pixel writes, rectangle fills and pixel reads. The front end takes one
// transaction per cycle while it is neither filling nor clearing and the job queue
// has room, and turns a fill into one pixel job per cycle while the job queue has
// room; full stays high for the whole fill walk. The back end serves one pixel job at
// a time through the frame store RAM: a blend write goes through locate, address
// multiply, RAM read and write back, and a read through locate, address multiply,
// RAM read and data capture before its result enters the result queue. After reset a
// clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT words (65536 by default) at one word
// per cycle; full is high during it while configuration writes are still taken.
module threshold_blend_rect_engine #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  tbre_pkg::in_item_t                   in_item,
  output logic                                 empty,
  input  logic                                 pop,
  output tbre_pkg::out_item_t                  out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tbre_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tbre_pkg::CFG_DATA_W-1:0]      cfg_data
);

  tbre_pkg::cfg_t      cfg;
  tbre_pkg::job_t      jq_wdata;
  tbre_pkg::job_t      jq_rdata;
  tbre_pkg::out_item_t res_wdata;
  logic                jq_push;
  logic                jq_full;
  logic                jq_pop;
  logic                jq_empty;
  logic                res_push;
  logic                res_full;
  logic                clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{origin_x: 12'd0, origin_y: 12'd0, region_width: 9'd256, region_height: 9'd256};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tbre_pkg::CFG_ORIGIN_X:      cfg.origin_x      <= cfg_data;
        tbre_pkg::CFG_ORIGIN_Y:      cfg.origin_y      <= cfg_data;
        tbre_pkg::CFG_REGION_WIDTH:  cfg.region_width  <= cfg_data[8:0];
        tbre_pkg::CFG_REGION_HEIGHT: cfg.region_height <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  tbre_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .clearing (clearing),
    .jq_full  (jq_full),
    .jq_push  (jq_push),
    .jq_data  (jq_wdata)
  );

  tbre_fifo #(
    .WIDTH ($bits(tbre_pkg::job_t)),
    .DEPTH (2)
  ) u_job_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (jq_push),
    .wr_data (jq_wdata),
    .full    (jq_full),
    .pop     (jq_pop),
    .rd_data (jq_rdata),
    .empty   (jq_empty)
  );

  tbre_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .jq_empty (jq_empty),
    .jq_data  (jq_rdata),
    .jq_pop   (jq_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_wdata),
    .clearing (clearing)
  );

  tbre_fifo #(
    .WIDTH ($bits(tbre_pkg::out_item_t)),
    .DEPTH (2)
  ) u_result_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_wdata),
    .full    (res_full),
    .pop     (pop),
    .rd_data (out_item),
    .empty   (empty)
  );

endmodule

// ----- rtl/core/tbre_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tbre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/tbre_fifo.sv -----
// Small register FIFO used for the job queue and the result queue.
module tbre_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- rtl/core/tbre_front.sv -----
// Front end: accepts transactions, classifies them and expands fills into pixel jobs.
module tbre_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  tbre_pkg::in_item_t in_item,
  input  logic               clearing,
  input  logic               jq_full,
  output logic               jq_push,
  output tbre_pkg::job_t     jq_data
);

  tbre_pkg::front_state_t state;
  tbre_pkg::front_state_t state_next;

  logic [8:0]  fill_column;
  logic [8:0]  fill_row;
  logic [11:0] base_x;
  logic [11:0] base_y;
  logic [31:0] colour;
  logic [8:0]  fill_w;
  logic [8:0]  fill_h;
  logic        last_col;
  logic        last_row;
  logic        accept;

  assign last_col = (fill_column == fill_w - 9'd1);
  assign last_row = (fill_row == fill_h - 9'd1);
  assign accept   = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbre_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    full       = clearing || (state == tbre_pkg::F_FILL) || jq_full;
    jq_push    = 1'b0;
    jq_data    = '{is_read: (in_item.operation == tbre_pkg::OP_READ),
                   x:       {1'b0, in_item.pos_x},
                   y:       {1'b0, in_item.pos_y},
                   pixel:   in_item.pixel};
    case (state)
      tbre_pkg::F_IDLE: begin
        if (accept) begin
          if (in_item.operation inside {tbre_pkg::OP_BLEND, tbre_pkg::OP_READ}) begin
            jq_push = 1'b1;
          end else if (in_item.operation == tbre_pkg::OP_FILL) begin
            if (in_item.rect_width != 9'd0 && in_item.rect_height != 9'd0) begin
              state_next = tbre_pkg::F_FILL;
            end
          end
        end
      end
      tbre_pkg::F_FILL: begin
        jq_data = '{is_read: 1'b0,
                    x:       {1'b0, base_x} + {4'b0, fill_column},
                    y:       {1'b0, base_y} + {4'b0, fill_row},
                    pixel:   colour};
        if (!jq_full) begin
          jq_push = 1'b1;
          if (last_col && last_row) begin
            state_next = tbre_pkg::F_IDLE;
          end
        end
      end
      default: begin
        state_next = tbre_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_column <= '0;
      fill_row    <= '0;
    end else if (state == tbre_pkg::F_FILL && !jq_full) begin
      if (last_col) begin
        fill_column <= '0;
        fill_row    <= last_row ? 9'd0 : fill_row + 9'd1;
      end else begin
        fill_column <= fill_column + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == tbre_pkg::F_IDLE && accept) begin
      base_x <= in_item.pos_x;
      base_y <= in_item.pos_y;
      colour <= in_item.pixel;
      fill_w <= in_item.rect_width;
      fill_h <= in_item.rect_height;
    end
  end

endmodule

// ----- rtl/core/tbre_back.sv -----
// Back end: locates pixel jobs in the frame store, blends writes and answers reads.
module tbre_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  tbre_pkg::cfg_t      cfg,
  input  logic                jq_empty,
  input  tbre_pkg::job_t      jq_data,
  output logic                jq_pop,
  input  logic                res_full,
  output logic                res_push,
  output tbre_pkg::out_item_t res_data,
  output logic                clearing
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tbre_pkg::back_state_t state;
  tbre_pkg::back_state_t state_next;

  tbre_pkg::job_t      job_q;
  tbre_pkg::out_item_t result_q;
  logic [12:0]         dx_q;
  logic [12:0]         dy_q;
  logic                inside_q;
  logic [AW-1:0]       addr_q;
  logic [AW-1:0]       clr_addr;

  logic [12:0] eff_w;
  logic [12:0] eff_h;
  logic [12:0] head_dx;
  logic [12:0] head_dy;
  logic        head_inside;
  logic [25:0] lin_addr;

  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [31:0]   ram_wr_data;
  logic          ram_rd_en;
  logic [31:0]   ram_rd_data;

  assign eff_w = ({4'b0, cfg.region_width} > 13'(MAX_WIDTH)) ?
                 13'(MAX_WIDTH) : {4'b0, cfg.region_width};
  assign eff_h = ({4'b0, cfg.region_height} > 13'(MAX_HEIGHT)) ?
                 13'(MAX_HEIGHT) : {4'b0, cfg.region_height};

  assign head_dx     = jq_data.x - {1'b0, cfg.origin_x};
  assign head_dy     = jq_data.y - {1'b0, cfg.origin_y};
  assign head_inside = (jq_data.x >= {1'b0, cfg.origin_x}) &&
                       (jq_data.y >= {1'b0, cfg.origin_y}) &&
                       (head_dx < eff_w) && (head_dy < eff_h);

  assign lin_addr = ({13'b0, dy_q} * {13'b0, eff_w}) + {13'b0, dx_q};

  assign res_data = result_q;
  assign clearing = (state == tbre_pkg::B_CLEAR);

  tbre_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (addr_q),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tbre_pkg::B_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == tbre_pkg::B_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_comb begin
    state_next  = state;
    jq_pop      = 1'b0;
    res_push    = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = addr_q;
    ram_wr_data = tbre_pkg::blend(ram_rd_data, job_q.pixel);
    ram_rd_en   = 1'b0;
    case (state)
      tbre_pkg::B_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr;
        ram_wr_data = '0;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = tbre_pkg::B_IDLE;
        end
      end
      tbre_pkg::B_IDLE: begin
        if (!jq_empty) begin
          jq_pop     = 1'b1;
          state_next = tbre_pkg::B_ADDR;
        end
      end
      tbre_pkg::B_ADDR: begin
        if (inside_q) begin
          state_next = tbre_pkg::B_READ;
        end else if (job_q.is_read) begin
          state_next = tbre_pkg::B_RESULT;
        end else begin
          state_next = tbre_pkg::B_IDLE;
        end
      end
      tbre_pkg::B_READ: begin
        ram_rd_en  = 1'b1;
        state_next = tbre_pkg::B_DATA;
      end
      tbre_pkg::B_DATA: begin
        if (job_q.is_read) begin
          state_next = tbre_pkg::B_RESULT;
        end else begin
          ram_wr_en  = 1'b1;
          state_next = tbre_pkg::B_IDLE;
        end
      end
      tbre_pkg::B_RESULT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = tbre_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = tbre_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      tbre_pkg::B_IDLE: begin
        job_q    <= jq_data;
        dx_q     <= head_dx;
        dy_q     <= head_dy;
        inside_q <= head_inside;
      end
      tbre_pkg::B_ADDR: begin
        addr_q   <= lin_addr[AW-1:0];
        result_q <= '{read_pixel: '0, out_of_range: 1'b1};
      end
      tbre_pkg::B_DATA: begin
        result_q <= '{read_pixel: ram_rd_data, out_of_range: 1'b0};
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/tbre_checker.sv -----
// Port-level assertion checker for the threshold blend rectangle engine, with its bind.
`include "threshold_blend_rect_engine_defines.svh"

module tbre_checker (
  input logic                clk,
  input logic                rst,
  input logic                push,
  input logic                full,
  input tbre_pkg::in_item_t  in_item,
  input logic                empty,
  input logic                pop,
  input tbre_pkg::out_item_t out_item
);

  logic fill_accept;

  assign fill_accept = push && !full && (in_item.operation == tbre_pkg::OP_FILL) &&
                       (in_item.rect_width != 9'd0) && (in_item.rect_height != 9'd0);

  // The clearing pass holds off input transactions right after reset.
  `TBRE_ASSERT_NEXT(a_full_after_reset, rst, full)

  // A read outside the region always reports a zero pixel.
  `TBRE_ASSERT_IMPLY(a_oor_pixel_zero, !empty && out_item.out_of_range, out_item.read_pixel == 32'd0)

  // A waiting result stays in place until it is taken.
  `TBRE_ASSERT_NEXT(a_result_holds, !rst && !empty && !pop, !empty && $stable(out_item))

  // A non-empty fill blocks the input while its pixels are walked.
  `TBRE_ASSERT_NEXT(a_fill_blocks_input, !rst && fill_accept, full)

endmodule

bind threshold_blend_rect_engine tbre_checker u_checker (.*);
